### hw/rtl/kvc_pkg.sv
// ----------------------------------------------------------------------------
// kvc_pkg
// shared constants, command/status types and code conversion functions
// for the int4 key/value cache store
// ----------------------------------------------------------------------------
package kvc_pkg;

  localparam int MAX_SLOTS      = 256;
  localparam int GROUP_COUNT    = 4;
  localparam int MAX_HEADS      = 8;
  localparam int ELEMS_PER_HEAD = 128;

  localparam int STORE_BYTES = MAX_SLOTS * GROUP_COUNT * MAX_HEADS * ELEMS_PER_HEAD;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int SLOT_W      = $clog2(MAX_SLOTS);
  localparam int DIV_W       = $clog2(MAX_SLOTS + 1);
  localparam int HEADS_W     = $clog2(MAX_HEADS + 1);
  localparam int PAIRS       = ELEMS_PER_HEAD / 2;

  localparam int TOK_W       = 32;
  localparam int CNT_W       = $clog2(TOK_W);
  localparam int SLOT_CNT_W  = 9;
  localparam int HEAD_CNT_W  = 4;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  typedef struct packed {
    logic clear;
    logic load;
    logic div_step;
    logic addr_calc;
    logic access;
  } kvc_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_last;
  } kvc_stat_t;

  // binary16 of k/7, round to nearest even
  function automatic logic [15:0] sevenths(input logic [3:0] k);
    logic [15:0] r;
    case (k)
      4'd0:    r = 16'h0000;
      4'd1:    r = 16'h3092;
      4'd2:    r = 16'h3492;
      4'd3:    r = 16'h36DB;
      4'd4:    r = 16'h3892;
      4'd5:    r = 16'h39B7;
      4'd6:    r = 16'h3ADB;
      4'd7:    r = 16'h3C00;
      4'd8:    r = 16'h3C92;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] dequantize(input logic [3:0] nib);
    logic [15:0] r;
    if (nib[3]) begin
      r = 16'h8000 | sevenths(4'(-nib));
    end else begin
      r = sevenths(nib);
    end
    return r;
  endfunction

  // binary16 -> signed 4-bit code, clamp to [-1,1], round half away from zero
  function automatic logic [3:0] quantize(input logic [15:0] h);
    logic [4:0]  expo;
    logic [9:0]  frac;
    logic [23:0] m;
    logic [27:0] prod;
    logic [3:0]  mag;
    logic [3:0]  r;
    expo = h[14:10];
    frac = h[9:0];
    if (expo == 5'd0) begin
      m = 24'(frac);
    end else begin
      m = 24'({1'b1, frac}) << (expo - 5'd1);
    end
    prod = 28'(m) * 28'd7 + 28'h0800000;
    mag  = prod[27:24];
    if (expo >= 5'd15) begin
      mag = 4'd7;
    end else if (mag > 4'd7) begin
      mag = 4'd7;
    end
    if (expo == 5'h1F && frac != 10'd0) begin
      r = 4'd0;
    end else if (h[15]) begin
      r = 4'(-mag);
    end else begin
      r = mag;
    end
    return r;
  endfunction

endpackage

### hw/rtl/int4_kv_cache_store.sv
// ----------------------------------------------------------------------------
// int4_kv_cache_store
// byte store for a 4-bit quantized key/value cache. after reset busy stays
// high for a clearing pass over all 1,048,576 bytes, one byte per cycle, while
// configuration writes are still taken. an item is taken when start is high
// and busy is low; its result appears on result_valid_o for exactly one
// cycle and cannot be stalled. the item steps through the bit-serial
// remainder of token_index by slot_count, then the byte address, the memory
// port access and the result. busy is high for the whole item, so one item
// is in flight at a time
// ----------------------------------------------------------------------------
module int4_kv_cache_store (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kvc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [kvc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [kvc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            start,
  output logic                            busy,
  input  logic                            action_i,
  input  logic [31:0]                     token_index_i,
  input  logic [1:0]                      layer_group_i,
  input  logic [2:0]                      head_index_i,
  input  logic                            half_select_i,
  input  logic [5:0]                      pair_index_i,
  input  logic [15:0]                     value_lo_i,
  input  logic [15:0]                     value_hi_i,
  output logic                            result_valid_o,
  output logic [15:0]                     read_lo_o,
  output logic [15:0]                     read_hi_o,
  output logic                            bad_address_o
);
  import kvc_pkg::*;

  logic [SLOT_CNT_W-1:0] slot_count;
  logic [HEAD_CNT_W-1:0] head_count;
  kvc_cmd_t              cmd;
  kvc_stat_t             stat;

  kvc_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .slot_count_o (slot_count),
    .head_count_o (head_count)
  );

  kvc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  kvc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .slot_count_i  (slot_count),
    .head_count_i  (head_count),
    .action_i      (action_i),
    .token_index_i (token_index_i),
    .layer_group_i (layer_group_i),
    .head_index_i  (head_index_i),
    .half_select_i (half_select_i),
    .pair_index_i  (pair_index_i),
    .value_lo_i    (value_lo_i),
    .value_hi_i    (value_hi_i),
    .read_lo_o     (read_lo_o),
    .read_hi_o     (read_hi_o),
    .bad_address_o (bad_address_o)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  a_result_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_result_in_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe outside an item");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && bad_address_o) |-> (read_lo_o == 16'h0000 && read_hi_o == 16'h0000))
    else $error("dropped access returned data");
`endif

endmodule

### hw/rtl/kvc_regs.sv
// ----------------------------------------------------------------------------
// kvc_regs
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
module kvc_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [kvc_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [kvc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [kvc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [kvc_pkg::SLOT_CNT_W-1:0]  slot_count_o,
  output logic [kvc_pkg::HEAD_CNT_W-1:0]  head_count_o
);
  import kvc_pkg::*;

  localparam logic REG_SLOT_COUNT = 1'b0;
  localparam logic REG_HEAD_COUNT = 1'b1;

  logic [SLOT_CNT_W-1:0] slot_count_q, slot_count_d;
  logic [HEAD_CNT_W-1:0] head_count_q, head_count_d;
  logic                  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    slot_count_d = slot_count_q;
    head_count_d = head_count_q;
    prdata       = '0;
    unique case (paddr[2])
      REG_SLOT_COUNT: begin
        prdata = APB_DATA_W'(slot_count_q);
        if (wr_en) begin
          slot_count_d = pwdata[SLOT_CNT_W-1:0];
        end
      end
      REG_HEAD_COUNT: begin
        prdata = APB_DATA_W'(head_count_q);
        if (wr_en) begin
          head_count_d = pwdata[HEAD_CNT_W-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SLOT_CNT_W'(1);
      head_count_q <= HEAD_CNT_W'(8);
    end else begin
      slot_count_q <= slot_count_d;
      head_count_q <= head_count_d;
    end
  end

  assign slot_count_o = slot_count_q;
  assign head_count_o = head_count_q;

endmodule

### hw/rtl/kvc_ctrl.sv
// ----------------------------------------------------------------------------
// kvc_ctrl
// sequencer: clearing pass, remainder steps, address, access, result
// ----------------------------------------------------------------------------
module kvc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               result_valid_o,
  input  kvc_pkg::kvc_stat_t stat_i,
  output kvc_pkg::kvc_cmd_t  cmd_o
);
  import kvc_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_ADDR   = 3'd3;
  localparam logic [2:0] ST_ACCESS = 3'd4;
  localparam logic [2:0] ST_RESP   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd_o.addr_calc = 1'b1;
        state_d         = ST_ACCESS;
      end
      ST_ACCESS: begin
        cmd_o.access = 1'b1;
        state_d      = ST_RESP;
      end
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_RESP);

endmodule

### hw/rtl/kvc_datapath.sv
// ----------------------------------------------------------------------------
// kvc_datapath
// bit-serial token remainder, byte address, packed int4 store and codecs
// ----------------------------------------------------------------------------
module kvc_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  kvc_pkg::kvc_cmd_t              cmd_i,
  output kvc_pkg::kvc_stat_t             stat_o,
  input  logic [kvc_pkg::SLOT_CNT_W-1:0] slot_count_i,
  input  logic [kvc_pkg::HEAD_CNT_W-1:0] head_count_i,
  input  logic                           action_i,
  input  logic [31:0]                    token_index_i,
  input  logic [1:0]                     layer_group_i,
  input  logic [2:0]                     head_index_i,
  input  logic                           half_select_i,
  input  logic [5:0]                     pair_index_i,
  input  logic [15:0]                    value_lo_i,
  input  logic [15:0]                    value_hi_i,
  output logic [15:0]                    read_lo_o,
  output logic [15:0]                    read_hi_o,
  output logic                           bad_address_o
);
  import kvc_pkg::*;

  localparam int TRIAL_W = DIV_W + 1;

  logic [7:0]        mem_q [STORE_BYTES];
  logic [ADDR_W-1:0] clr_q;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [TOK_W-1:0]  tok_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SLOT_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0]  slots;
  logic [HEADS_W-1:0] heads;
  logic [TRIAL_W-1:0] trial;
  logic              action_q, bad_q, bad_d, half_q;
  logic [1:0]        group_q;
  logic [2:0]        head_q;
  logic [5:0]        pair_q;
  logic [15:0]       val_lo_q, val_hi_q;
  logic [7:0]        rdata_q;
  logic [7:0]        wbyte;

  // effective slot and head counts
  always_comb begin
    if (slot_count_i == '0) begin
      slots = DIV_W'(1);
    end else if (32'(slot_count_i) > MAX_SLOTS) begin
      slots = DIV_W'(MAX_SLOTS);
    end else begin
      slots = DIV_W'(slot_count_i);
    end
    if (32'(head_count_i) > MAX_HEADS) begin
      heads = HEADS_W'(MAX_HEADS);
    end else begin
      heads = HEADS_W'(head_count_i);
    end
  end

  assign bad_d = (32'(layer_group_i) >= GROUP_COUNT) ||
                 (32'(head_index_i) >= 32'(heads)) ||
                 (32'(pair_index_i) >= PAIRS);

  // restoring remainder step
  always_comb begin
    trial = TRIAL_W'({rem_q, tok_q[TOK_W-1]});
    if (trial >= TRIAL_W'(slots)) begin
      rem_d = SLOT_W'(trial - TRIAL_W'(slots));
    end else begin
      rem_d = SLOT_W'(trial);
    end
  end

  assign addr_d = ADDR_W'(
      ((ADDR_W'(rem_q) * ADDR_W'(GROUP_COUNT) + ADDR_W'(group_q)) * ADDR_W'(heads)
        + ADDR_W'(head_q)) * ADDR_W'(ELEMS_PER_HEAD)
      + ADDR_W'(half_q) * ADDR_W'(PAIRS) + ADDR_W'(pair_q));

  assign wbyte = {quantize(val_hi_q), quantize(val_lo_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tok_q    <= token_index_i;
      rem_q    <= '0;
      action_q <= action_i;
      bad_q    <= bad_d;
      group_q  <= layer_group_i;
      head_q   <= head_index_i;
      half_q   <= half_select_i;
      pair_q   <= pair_index_i;
      val_lo_q <= value_lo_i;
      val_hi_q <= value_hi_i;
    end else if (cmd_i.div_step) begin
      tok_q <= {tok_q[TOK_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
    if (cmd_i.addr_calc) begin
      addr_q <= addr_d;
    end
  end

  // byte store
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_q[clr_q] <= 8'h00;
    end else if (cmd_i.access && !bad_q && !action_q) begin
      mem_q[addr_q] <= wbyte;
    end
    if (cmd_i.access) begin
      rdata_q <= mem_q[addr_q];
    end
  end

  assign stat_o.clear_last = (clr_q == ADDR_W'(STORE_BYTES - 1));
  assign stat_o.div_last   = (cnt_q == CNT_W'(TOK_W - 1));

  assign read_lo_o     = (action_q && !bad_q) ? dequantize(rdata_q[3:0]) : 16'h0000;
  assign read_hi_o     = (action_q && !bad_q) ? dequantize(rdata_q[7:4]) : 16'h0000;
  assign bad_address_o = bad_q;

endmodule
